[hdl/cacc_pkg.sv]
// ----------------------------------------------------------------------------
// cacc_pkg
// Shared types and constants for the CAN alive counter checker.
// ----------------------------------------------------------------------------
package cacc_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	localparam int ID_W    = 29;
	localparam int LEN_W   = 4;
	localparam int DATA_W  = 64;
	localparam int CTR_W   = 8;
	localparam int SKIP_W  = 16;
	localparam int STAT_W  = 3;
	localparam int CBI_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [SKIP_W-1:0] SKIP_MAX      = '1;
	localparam logic [SKIP_W-1:0] WARN_THR_RST  = 16'd10;
	localparam logic [CBI_W-1:0]  CBI_RST       = '0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_BYTE_INDEX = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WARNING_THRESHOLD  = 1'd1;

	// operation codes
	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_IGNORED  = 3'd0,
		ST_FULL     = 3'd1,
		ST_LEARNED  = 3'd2,
		ST_SEQUENCE = 3'd3,
		ST_REPEAT   = 3'd4,
		ST_SKIP     = 3'd5,
		ST_CLEARED  = 3'd6
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [CTR_W-1:0]  last_ctr;
		logic [SKIP_W-1:0] skips;
	} entry_t;

endpackage

[hdl/cacc_if.sv]
// ----------------------------------------------------------------------------
// cacc_if
// Frame and result channels of the alive counter checker (valid/ready).
// ----------------------------------------------------------------------------
interface cacc_frame_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [cacc_pkg::ID_W-1:0]   can_id;
	logic [cacc_pkg::LEN_W-1:0]  frame_length;
	logic [cacc_pkg::DATA_W-1:0] payload;

	modport source (output valid, op, can_id, frame_length, payload, input ready);
	modport sink   (input valid, op, can_id, frame_length, payload, output ready);
	modport mon    (input valid, ready, op, can_id, frame_length, payload);
endinterface

interface cacc_result_if;
	logic                        valid;
	logic                        ready;
	logic [cacc_pkg::STAT_W-1:0] status;
	logic                        severity;
	logic [cacc_pkg::CTR_W-1:0]  expected_counter;
	logic [cacc_pkg::CTR_W-1:0]  actual_counter;
	logic [cacc_pkg::SKIP_W-1:0] skip_count;

	modport source (output valid, status, severity, expected_counter, actual_counter,
		skip_count, input ready);
	modport sink   (input valid, status, severity, expected_counter, actual_counter,
		skip_count, output ready);
	modport mon    (input valid, ready, status, severity, expected_counter,
		actual_counter, skip_count);
endinterface

[hdl/cacc_table.sv]
// ----------------------------------------------------------------------------
// cacc_table
// Identifier table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cacc_table (
	input  logic                       clk,
	input  logic                       we,
	input  logic [cacc_pkg::IDX_W-1:0] waddr,
	input  cacc_pkg::entry_t           wdata,
	input  logic [cacc_pkg::IDX_W-1:0] raddr,
	output cacc_pkg::entry_t           rdata
);

	cacc_pkg::entry_t mem_q [cacc_pkg::TABLE_DEPTH];
	cacc_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/can_alive_counter_checker_core.sv]
// ----------------------------------------------------------------------------
// can_alive_counter_checker_core
// Rolling counter check per CAN identifier with a learned identifier table.
// ----------------------------------------------------------------------------
// A clear or a zero-length frame gives its result at the edge after it is
// taken. Any other frame scans the identifier table one entry per cycle
// through the single read port of the table RAM, up to N entries, N being
// the number of identifiers stored (at most 256 with a full table). The next
// frame is taken once the block is back in idle and the result register is
// empty or being emptied. The table needs no clearing after reset; only
// entries below the fill count are ever compared.
module can_alive_counter_checker_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cacc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cacc_pkg::CFG_DATA_W-1:0] cfg_data,
	cacc_frame_if.sink                      frame,
	cacc_result_if.source                   result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_UPDATE,
		S_LEARN
	} state_t;

	state_t                              state_q;
	logic [cacc_pkg::CBI_W-1:0]          cbi_q;
	logic [cacc_pkg::SKIP_W-1:0]         thr_q;
	logic [cacc_pkg::CNT_W-1:0]          count_q;
	logic [cacc_pkg::CNT_W-1:0]          scan_q;
	logic                                pend_q;
	logic [cacc_pkg::IDX_W-1:0]          pidx_q;
	logic [cacc_pkg::IDX_W-1:0]          hit_idx_q;
	cacc_pkg::entry_t                    hit_q;
	logic [cacc_pkg::ID_W-1:0]           id_q;
	logic [cacc_pkg::CTR_W-1:0]          cur_q;

	logic                                res_valid_q;
	cacc_pkg::status_t                   res_status_q;
	logic                                res_sev_q;
	logic [cacc_pkg::CTR_W-1:0]          res_exp_q;
	logic [cacc_pkg::CTR_W-1:0]          res_act_q;
	logic [cacc_pkg::SKIP_W-1:0]         res_skips_q;

	logic                                accept;
	logic                                res_load;
	logic                                issue;
	logic                                hit;
	logic [cacc_pkg::CTR_W-1:0]          cur_sel;
	logic [cacc_pkg::CTR_W-1:0]          expected;
	logic                                in_seq;
	logic                                is_rep;
	logic [cacc_pkg::SKIP_W-1:0]         skips_inc;
	logic [cacc_pkg::SKIP_W-1:0]         skips_new;
	logic                                full;

	logic                                tbl_we;
	logic [cacc_pkg::IDX_W-1:0]          tbl_waddr;
	cacc_pkg::entry_t                    tbl_wdata;
	cacc_pkg::entry_t                    tbl_rdata;

	assign frame.ready = (state_q == S_IDLE) && (!res_valid_q || result.ready);
	assign accept      = frame.valid && frame.ready;
	assign cur_sel     = frame.payload[{cbi_q, 3'b000} +: cacc_pkg::CTR_W];

	// a new result is loaded by a clear, an empty frame, an update or a learn
	assign res_load = (state_q == S_UPDATE) || (state_q == S_LEARN)
		|| (accept && (frame.op == cacc_pkg::OP_CLEAR || frame.frame_length == '0));

	// scan: address issued this cycle, data of the previous one compared
	assign issue = scan_q < count_q;
	assign hit   = pend_q && (tbl_rdata.id == id_q);

	assign expected  = hit_q.last_ctr + cacc_pkg::CTR_W'(1);
	assign in_seq    = cur_q == expected;
	assign is_rep    = cur_q == hit_q.last_ctr;
	assign skips_inc = (hit_q.skips == cacc_pkg::SKIP_MAX) ? hit_q.skips
		: hit_q.skips + cacc_pkg::SKIP_W'(1);
	assign skips_new = (in_seq || is_rep) ? hit_q.skips : skips_inc;
	assign full      = count_q >= cacc_pkg::CNT_W'(cacc_pkg::TABLE_DEPTH);

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = hit_idx_q;
		tbl_wdata = '{id: id_q, last_ctr: cur_q, skips: skips_new};
		case (state_q)
			S_UPDATE: begin
				tbl_we = 1'b1;
			end
			S_LEARN: begin
				tbl_we    = !full;
				tbl_waddr = count_q[cacc_pkg::IDX_W-1:0];
				tbl_wdata = '{id: id_q, last_ctr: cur_q, skips: '0};
			end
			default: begin
				tbl_we = 1'b0;
			end
		endcase
	end

	cacc_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (scan_q[cacc_pkg::IDX_W-1:0]),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cbi_q        <= cacc_pkg::CBI_RST;
			thr_q        <= cacc_pkg::WARN_THR_RST;
			count_q      <= '0;
			scan_q       <= '0;
			pend_q       <= 1'b0;
			res_valid_q  <= 1'b0;
			res_status_q <= cacc_pkg::ST_IGNORED;
			res_sev_q    <= 1'b0;
			res_exp_q    <= '0;
			res_act_q    <= '0;
			res_skips_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cacc_pkg::CFG_COUNTER_BYTE_INDEX: cbi_q <= cfg_data[cacc_pkg::CBI_W-1:0];
					cacc_pkg::CFG_WARNING_THRESHOLD:  thr_q <= cfg_data;
					default: ;
				endcase
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (frame.op == cacc_pkg::OP_CLEAR) begin
							count_q      <= '0;
							res_status_q <= cacc_pkg::ST_CLEARED;
							res_sev_q    <= 1'b0;
							res_exp_q    <= '0;
							res_act_q    <= '0;
							res_skips_q  <= '0;
						end else if (frame.frame_length == '0) begin
							res_status_q <= cacc_pkg::ST_IGNORED;
							res_sev_q    <= 1'b0;
							res_exp_q    <= '0;
							res_act_q    <= '0;
							res_skips_q  <= '0;
						end else begin
							id_q    <= frame.can_id;
							cur_q   <= cur_sel;
							scan_q  <= '0;
							pend_q  <= 1'b0;
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					pend_q <= issue;
					pidx_q <= scan_q[cacc_pkg::IDX_W-1:0];
					if (issue) begin
						scan_q <= scan_q + cacc_pkg::CNT_W'(1);
					end
					if (hit) begin
						hit_q     <= tbl_rdata;
						hit_idx_q <= pidx_q;
						state_q   <= S_UPDATE;
					end else if (!pend_q && !issue) begin
						state_q <= S_LEARN;
					end
				end
				S_UPDATE: begin
					res_exp_q   <= expected;
					res_act_q   <= cur_q;
					res_skips_q <= skips_new;
					if (in_seq) begin
						res_status_q <= cacc_pkg::ST_SEQUENCE;
						res_sev_q    <= 1'b0;
					end else if (is_rep) begin
						res_status_q <= cacc_pkg::ST_REPEAT;
						res_sev_q    <= 1'b0;
					end else begin
						res_status_q <= cacc_pkg::ST_SKIP;
						res_sev_q    <= skips_new > thr_q;
					end
					state_q <= S_IDLE;
				end
				S_LEARN: begin
					res_sev_q   <= 1'b0;
					res_exp_q   <= '0;
					res_act_q   <= cur_q;
					res_skips_q <= '0;
					if (full) begin
						res_status_q <= cacc_pkg::ST_FULL;
					end else begin
						res_status_q <= cacc_pkg::ST_LEARNED;
						count_q      <= count_q + cacc_pkg::CNT_W'(1);
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result.valid            = res_valid_q;
	assign result.status           = res_status_q;
	assign result.severity         = res_sev_q;
	assign result.expected_counter = res_exp_q;
	assign result.actual_counter   = res_act_q;
	assign result.skip_count       = res_skips_q;

endmodule

[hdl/cacc_checker.sv]
// ----------------------------------------------------------------------------
// cacc_checker
// Port-level checks for the alive counter checker, bound to the core.
// ----------------------------------------------------------------------------
module cacc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              frame_valid,
	input logic                              frame_ready,
	input logic                              frame_op,
	input logic [cacc_pkg::LEN_W-1:0]        frame_len,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [cacc_pkg::STAT_W-1:0]       res_status,
	input logic                              res_severity,
	input logic [cacc_pkg::CTR_W-1:0]        res_expected,
	input logic [cacc_pkg::SKIP_W-1:0]       res_skips
);

	// a pending result holds until the transaction completes
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before it was taken");

	a_clear_res: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_ready && frame_op == cacc_pkg::OP_CLEAR
		|=> res_valid && res_status == cacc_pkg::ST_CLEARED)
		else $error("clear did not report cleared");

	a_ignore_res: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_ready && frame_op == cacc_pkg::OP_CHECK
		&& frame_len == '0
		|=> res_valid && res_status == cacc_pkg::ST_IGNORED)
		else $error("empty frame did not report ignored");

	a_sev_skip: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_severity |-> res_status == cacc_pkg::ST_SKIP)
		else $error("warning severity on a non-skip result");

	a_no_hist: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == cacc_pkg::ST_LEARNED
		|| res_status == cacc_pkg::ST_FULL)
		|-> res_expected == '0 && res_skips == '0)
		else $error("new identifier reported counter history");

endmodule

bind can_alive_counter_checker_core cacc_checker u_cacc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.frame_valid  (frame.valid),
	.frame_ready  (frame.ready),
	.frame_op     (frame.op),
	.frame_len    (frame.frame_length),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_status   (result.status),
	.res_severity (result.severity),
	.res_expected (result.expected_counter),
	.res_skips    (result.skip_count)
);

[tb/tb_can_alive_counter_checker_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_can_alive_counter_checker_core
// Self-checking bench for the CAN alive counter checker. A driver feeds
// frames from a queue, a shadow identifier table predicts every result and a
// monitor compares each result transaction field by field. Covers directed
// corner frames, random per-identifier counter streams, a full table and a
// long skip run that crosses the warning threshold, under several register
// setups.
// ----------------------------------------------------------------------------
module tb_can_alive_counter_checker_core;

	typedef struct packed {
		logic                        op;
		logic [cacc_pkg::ID_W-1:0]   id;
		logic [cacc_pkg::LEN_W-1:0]  len;
		logic [cacc_pkg::DATA_W-1:0] payload;
	} frame_t;

	typedef struct packed {
		cacc_pkg::status_t           status;
		logic                        severity;
		logic [cacc_pkg::CTR_W-1:0]  exp_ctr;
		logic [cacc_pkg::CTR_W-1:0]  act_ctr;
		logic [cacc_pkg::SKIP_W-1:0] skips;
	} verdict_t;

	// odd multiplier: i * ID_SPREAD gives distinct 29-bit identifiers
	localparam logic [31:0] ID_SPREAD = 32'h0ABCDEF1;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [cacc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cacc_pkg::CFG_DATA_W-1:0] cfg_data;

	cacc_frame_if  frame_ch();
	cacc_result_if result_ch();

	can_alive_counter_checker_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame     (frame_ch),
		.result    (result_ch)
	);

	always #5 clk = ~clk;

	// shadow of the block's registers and identifier table
	logic [cacc_pkg::CBI_W-1:0]  cfg_cbi;
	logic [cacc_pkg::SKIP_W-1:0] cfg_thr;
	int                          known_cnt;
	logic [cacc_pkg::ID_W-1:0]   known_id    [cacc_pkg::TABLE_DEPTH];
	logic [cacc_pkg::CTR_W-1:0]  known_ctr   [cacc_pkg::TABLE_DEPTH];
	logic [cacc_pkg::SKIP_W-1:0] known_skips [cacc_pkg::TABLE_DEPTH];

	frame_t   frame_q[$];
	verdict_t verdict_q[$];
	int       frames_open;
	int       src_idle_pct;
	int       snk_stall_pct;
	int       mismatches;
	int       results_seen;
	int       reg_writes;
	int       status_seen [8];

	function automatic verdict_t predict_frame(frame_t f);
		verdict_t                   v;
		logic [cacc_pkg::CTR_W-1:0] cur;
		logic [cacc_pkg::CTR_W-1:0] prev;
		logic [cacc_pkg::CTR_W-1:0] nxt;
		int                         hit;
		int                         i;
		v = '0;
		if (f.op == cacc_pkg::OP_CLEAR) begin
			known_cnt = 0;
			v.status = cacc_pkg::ST_CLEARED;
			return v;
		end
		if (f.len == '0)
			return v;
		cur = f.payload[cfg_cbi*8 +: 8];
		v.act_ctr = cur;
		hit = -1;
		for (i = 0; i < known_cnt; i++)
			if (hit < 0 && known_id[i] == f.id)
				hit = i;
		if (hit < 0) begin
			if (known_cnt >= cacc_pkg::TABLE_DEPTH) begin
				v.status = cacc_pkg::ST_FULL;
				return v;
			end
			known_id[known_cnt]    = f.id;
			known_ctr[known_cnt]   = cur;
			known_skips[known_cnt] = '0;
			known_cnt++;
			v.status = cacc_pkg::ST_LEARNED;
			return v;
		end
		// compare against the stored counter, then store the new one
		prev = known_ctr[hit];
		nxt = prev + 8'd1;
		known_ctr[hit] = cur;
		v.exp_ctr = nxt;
		v.skips = known_skips[hit];
		if (cur == nxt) begin
			v.status = cacc_pkg::ST_SEQUENCE;
		end else if (cur == prev) begin
			v.status = cacc_pkg::ST_REPEAT;
		end else begin
			if (known_skips[hit] != cacc_pkg::SKIP_MAX)
				known_skips[hit] = known_skips[hit] + 16'd1;
			v.skips = known_skips[hit];
			v.status = cacc_pkg::ST_SKIP;
			v.severity = (v.skips > cfg_thr);
		end
		return v;
	endfunction

	function automatic frame_t build_frame(logic op, logic [cacc_pkg::ID_W-1:0] id,
		logic [cacc_pkg::LEN_W-1:0] len, logic [cacc_pkg::CTR_W-1:0] ctr);
		frame_t f;
		f.op = op;
		f.id = id;
		f.len = len;
		f.payload = {$urandom, $urandom};
		f.payload[cfg_cbi*8 +: 8] = ctr;
		return f;
	endfunction

	// mostly legal lengths, now and then 9..15
	function automatic logic [cacc_pkg::LEN_W-1:0] pick_len();
		if ($urandom_range(9, 0) == 0)
			return cacc_pkg::LEN_W'($urandom_range(15, 9));
		return cacc_pkg::LEN_W'($urandom_range(8, 1));
	endfunction

	task automatic queue_frame(frame_t f);
		frame_q.push_back(f);
		frames_open++;
	endtask

	task automatic wait_idle();
		while (frames_open != 0 || verdict_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [cacc_pkg::CFG_IDX_W-1:0] idx,
		logic [cacc_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == cacc_pkg::CFG_COUNTER_BYTE_INDEX)
			cfg_cbi = val[cacc_pkg::CBI_W-1:0];
		else
			cfg_thr = val;
		reg_writes++;
	endtask

	// upper data bits are random; only the low three bits select the byte
	task automatic set_config(logic [cacc_pkg::CBI_W-1:0] cbi,
		logic [cacc_pkg::SKIP_W-1:0] thr);
		write_reg(cacc_pkg::CFG_COUNTER_BYTE_INDEX, {13'($urandom), cbi});
		write_reg(cacc_pkg::CFG_WARNING_THRESHOLD, thr);
	endtask

	// counter streams over a small identifier pool with some noise mixed in
	task automatic run_random(int n, int pool_n);
		logic [cacc_pkg::ID_W-1:0]  pool [16];
		logic [cacc_pkg::CTR_W-1:0] last [16];
		int                         k;
		int                         r;
		int                         p;
		for (k = 0; k < pool_n; k++) begin
			pool[k] = (k % 2) ? cacc_pkg::ID_W'($urandom_range(2047, 0))
				: cacc_pkg::ID_W'($urandom);
			last[k] = 8'($urandom);
		end
		for (k = 0; k < n; k++) begin
			r = $urandom_range(99, 0);
			p = $urandom_range(pool_n - 1, 0);
			if (r < 2) begin
				queue_frame(build_frame(cacc_pkg::OP_CLEAR, cacc_pkg::ID_W'($urandom),
					cacc_pkg::LEN_W'($urandom), 8'($urandom)));
			end else if (r < 6) begin
				queue_frame(build_frame(cacc_pkg::OP_CHECK, pool[p], '0, 8'($urandom)));
			end else if (r < 10) begin
				queue_frame(build_frame(cacc_pkg::OP_CHECK, cacc_pkg::ID_W'($urandom),
					pick_len(), 8'($urandom)));
			end else begin
				if (r < 65)
					last[p] = last[p] + 8'd1;
				else if (r < 80)
					last[p] = last[p];
				else
					last[p] = 8'($urandom);
				queue_frame(build_frame(cacc_pkg::OP_CHECK, pool[p], pick_len(), last[p]));
			end
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				verdict_q.push_back(predict_frame({frame_ch.op, frame_ch.can_id,
					frame_ch.frame_length, frame_ch.payload}));
				frames_open--;
			end
			if (!frame_ch.valid || frame_ch.ready) begin
				if (frame_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
					frame_t f;
					f = frame_q.pop_front();
					frame_ch.valid        <= 1'b1;
					frame_ch.op           <= f.op;
					frame_ch.can_id       <= f.id;
					frame_ch.frame_length <= f.len;
					frame_ch.payload      <= f.payload;
				end else begin
					frame_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				verdict_t want;
				results_seen++;
				status_seen[result_ch.status]++;
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR %0t: result with none pending: status=%0d", $realtime,
							result_ch.status);
				end else begin
					want = verdict_q.pop_front();
					if (result_ch.status !== want.status || result_ch.severity !== want.severity ||
						result_ch.expected_counter !== want.exp_ctr ||
						result_ch.actual_counter !== want.act_ctr ||
						result_ch.skip_count !== want.skips) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"ERROR %0t: exp status=%0d sev=%0d exp_ctr=%02h act_ctr=%02h",
								" skips=%0d, got status=%0d sev=%0d exp_ctr=%02h act_ctr=%02h",
								" skips=%0d"}, $realtime, want.status, want.severity,
								want.exp_ctr, want.act_ctr, want.skips, result_ch.status,
								result_ch.severity, result_ch.expected_counter,
								result_ch.actual_counter, result_ch.skip_count);
					end
				end
			end
			result_ch.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
		end
	end

	initial begin
		#40ms;
		$display("Timeout: results still outstanding");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [cacc_pkg::CTR_W-1:0] ctr;
		int                         i;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		frame_ch.valid = 1'b0;
		frame_ch.op = cacc_pkg::OP_CHECK;
		frame_ch.can_id = '0;
		frame_ch.frame_length = '0;
		frame_ch.payload = '0;
		result_ch.ready = 1'b0;
		cfg_cbi = cacc_pkg::CBI_RST;
		cfg_thr = cacc_pkg::WARN_THR_RST;
		known_cnt = 0;
		frames_open = 0;
		mismatches = 0;
		results_seen = 0;
		reg_writes = 0;
		foreach (status_seen[j])
			status_seen[j] = 0;
		src_idle_pct = 20;
		snk_stall_pct = 76;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners: counter in byte 0, default threshold
		set_config(3'd0, 16'd10);
		queue_frame(build_frame(cacc_pkg::OP_CHECK, '0, '0, 8'h00));
		queue_frame(frame_t'{cacc_pkg::OP_CLEAR, '1, '1, '1});
		queue_frame(build_frame(cacc_pkg::OP_CHECK, '0, 4'd8, 8'hFF));
		queue_frame(build_frame(cacc_pkg::OP_CHECK, '0, 4'd8, 8'h00));   // wraps to zero
		queue_frame(build_frame(cacc_pkg::OP_CHECK, '0, 4'd1, 8'h00));
		queue_frame(build_frame(cacc_pkg::OP_CHECK, '0, 4'd8, 8'h05));
		queue_frame(frame_t'{cacc_pkg::OP_CHECK, '1, '1, '1});
		queue_frame(frame_t'{cacc_pkg::OP_CHECK, '1, 4'd9, '0});
		queue_frame(frame_t'{cacc_pkg::OP_CHECK, '0, 4'd8, '0});
		queue_frame(build_frame(cacc_pkg::OP_CHECK, 29'h7FF, 4'd8, 8'h80));
		queue_frame(build_frame(cacc_pkg::OP_CHECK, 29'h7FF, 4'd8, 8'h7F));
		// keep skipping id 0 until alerts turn into warnings
		for (i = 1; i <= 10; i++)
			queue_frame(build_frame(cacc_pkg::OP_CHECK, '0, 4'd8, 8'(i * 16)));
		queue_frame(frame_t'{cacc_pkg::OP_CLEAR, '0, '0, '0});
		queue_frame(build_frame(cacc_pkg::OP_CHECK, '0, 4'd3, 8'h33));
		run_random(120, 12);
		wait_idle();

		// counter in the top byte, every skip a warning
		src_idle_pct = 76;
		snk_stall_pct = 20;
		set_config(3'd7, 16'd0);
		queue_frame(build_frame(cacc_pkg::OP_CHECK, 29'h123, 4'd1, 8'h40));
		queue_frame(build_frame(cacc_pkg::OP_CHECK, 29'h123, 4'd2, 8'h42));
		run_random(60, 10);
		// fill the table, then mix known identifiers with ones that find no room
		queue_frame(build_frame(cacc_pkg::OP_CLEAR, cacc_pkg::ID_W'($urandom),
			cacc_pkg::LEN_W'($urandom), 8'($urandom)));
		for (i = 0; i < cacc_pkg::TABLE_DEPTH; i++)
			queue_frame(build_frame(cacc_pkg::OP_CHECK, cacc_pkg::ID_W'(i * ID_SPREAD),
				pick_len(), 8'($urandom)));
		for (i = 0; i < 40; i++) begin
			if ($urandom_range(9, 0) == 0)
				queue_frame(build_frame(cacc_pkg::OP_CHECK, cacc_pkg::ID_W'($urandom), '0,
					8'($urandom)));
			else if ($urandom_range(1, 0) == 0)
				queue_frame(build_frame(cacc_pkg::OP_CHECK,
					cacc_pkg::ID_W'($urandom_range(cacc_pkg::TABLE_DEPTH - 1, 0) * ID_SPREAD),
					pick_len(), 8'($urandom)));
			else
				queue_frame(build_frame(cacc_pkg::OP_CHECK, cacc_pkg::ID_W'($urandom),
					pick_len(), 8'($urandom)));
		end
		wait_idle();

		// back to back: one identifier skips past the threshold, then a sequence and a repeat
		src_idle_pct = 0;
		snk_stall_pct = 0;
		set_config(3'd5, 16'd20);
		queue_frame(build_frame(cacc_pkg::OP_CLEAR, '0, '0, '0));
		ctr = 8'($urandom);
		queue_frame(build_frame(cacc_pkg::OP_CHECK, 29'h155, 4'd8, ctr));
		for (i = 0; i < 40; i++) begin
			ctr = ctr + 8'd2 + 8'($urandom_range(253, 0));
			queue_frame(build_frame(cacc_pkg::OP_CHECK, 29'h155, pick_len(), ctr));
		end
		queue_frame(build_frame(cacc_pkg::OP_CHECK, 29'h155, 4'd8, ctr + 8'd1));
		queue_frame(build_frame(cacc_pkg::OP_CHECK, 29'h155, 4'd8, ctr + 8'd1));
		wait_idle();

		set_config(3'd2, 16'd65535);
		run_random(60, 6);
		wait_idle();
		repeat (300) @(posedge clk);

		if (verdict_q.size() != 0) begin
			mismatches++;
			$display("ERROR: %0d results never arrived", verdict_q.size());
		end
		$display("Checked %0d results: %0d learned, %0d in sequence, %0d repeats, %0d skips",
			results_seen, status_seen[cacc_pkg::ST_LEARNED], status_seen[cacc_pkg::ST_SEQUENCE],
			status_seen[cacc_pkg::ST_REPEAT], status_seen[cacc_pkg::ST_SKIP]);
		$display("Also %0d table full, %0d ignored, %0d clears, %0d register writes, %0d mismatches",
			status_seen[cacc_pkg::ST_FULL], status_seen[cacc_pkg::ST_IGNORED],
			status_seen[cacc_pkg::ST_CLEARED], reg_writes, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
